// ===== hdl/bnss_pkg.sv =====
package bnss_pkg;

	localparam int BNSS_MAX_CHANNELS = 256;
	localparam int BNSS_SHIFT_W      = 28;
	localparam int BNSS_SUM_W        = 29;

	typedef enum logic {
		REQ_LOAD   = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_t;

	typedef struct packed {
		logic [3:0]        shift_code;
		logic signed [7:0] offset;
		logic signed [7:0] scale;
	} param_t;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_out;
	} pipe_ctl_t;

	// codes 0-7 shift left, 8 passes, 9-15 shift right (arithmetic)
	function automatic logic signed [BNSS_SHIFT_W-1:0] apply_shift(
		input logic signed [15:0] p,
		input logic [3:0]         code
	);
		logic signed [BNSS_SHIFT_W-1:0] x;
		logic signed [BNSS_SHIFT_W-1:0] r;
		x = BNSS_SHIFT_W'(p);
		case (code)
			4'd0:    r = x <<< 12;
			4'd1:    r = x <<< 10;
			4'd2:    r = x <<< 8;
			4'd3:    r = x <<< 6;
			4'd4:    r = x <<< 4;
			4'd5:    r = x <<< 3;
			4'd6:    r = x <<< 2;
			4'd7:    r = x <<< 1;
			4'd8:    r = x;
			4'd9:    r = x >>> 1;
			4'd10:   r = x >>> 2;
			4'd11:   r = x >>> 3;
			4'd12:   r = x >>> 4;
			4'd13:   r = x >>> 6;
			4'd14:   r = x >>> 8;
			4'd15:   r = x >>> 10;
			default: r = x;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/bnss_param_mem.sv =====
module bnss_param_mem
	import bnss_pkg::*;
#(
	parameter int DEPTH = BNSS_MAX_CHANNELS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  param_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output param_t        rdata
);

	param_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/bnss_datapath.sv =====
module bnss_datapath
	import bnss_pkg::*;
(
	input  logic              clk,
	input  pipe_ctl_t         ctl,
	input  logic signed [7:0] sample,
	input  logic              en,
	input  logic              in_range,
	input  param_t            rd,
	output logic signed [7:0] result
);

	logic signed [7:0]  sample_s1;
	logic               en_s1;
	logic               range_s1;

	logic signed [15:0] prod_s2;
	logic signed [7:0]  offset_s2;
	logic [3:0]         code_s2;
	logic signed [7:0]  sample_s2;
	logic               en_s2;

	logic signed [7:0]  scale_sel;
	logic signed [7:0]  offset_sel;
	logic [3:0]         code_sel;
	logic signed [15:0] prod;

	logic signed [BNSS_SHIFT_W-1:0] shifted;
	logic signed [BNSS_SUM_W-1:0]   sum;
	logic signed [15:0]             sat;

	logic signed [7:0] result_q;

	// channel beyond table reads as an all-zero entry
	assign scale_sel  = range_s1 ? rd.scale      : 8'sd0;
	assign offset_sel = range_s1 ? rd.offset     : 8'sd0;
	assign code_sel   = range_s1 ? rd.shift_code : 4'd0;
	assign prod       = 16'(sample_s1) * 16'(scale_sel);

	assign shifted = apply_shift(prod_s2, code_s2);
	assign sum     = BNSS_SUM_W'(shifted)
	               + $signed({{(BNSS_SUM_W-16){offset_s2[7]}}, offset_s2, 8'h00});

	always_comb begin
		if (sum > BNSS_SUM_W'(32767)) begin
			sat = 16'sh7fff;
		end else if (sum < -BNSS_SUM_W'(32768)) begin
			sat = -16'sh8000;
		end else begin
			sat = sum[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			sample_s1 <= sample;
			en_s1     <= en;
			range_s1  <= in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			prod_s2   <= prod;
			offset_s2 <= offset_sel;
			code_s2   <= code_sel;
			sample_s2 <= sample_s1;
			en_s2     <= en_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			result_q <= en_s2 ? sat[15:8] : sample_s2;
		end
	end

	assign result = result_q;

endmodule

// ===== hdl/batch_norm_scale_shift_saturate.sv =====
// Per-channel batch normalization: scale, shift, offset, saturate.
// Input channel (in_valid/in_ready): a load beat (req_type 0) writes the
// channel's scale, offset and shift code into the parameter RAM and gives
// no result; a sample beat (req_type 1) gives one result.
// Output channel (out_valid/out_ready): one result per sample beat, in order.
// cfg_we/cfg_wdata write norm_enable; write it only while the block is idle.
// Throughput: one beat per cycle while out_ready stays high, with one read or
// one write of the parameter RAM per beat; the multiplier is 8x8.
// Pipeline: the accepting edge reads the RAM into stage 1, stage 2 holds the
// multiply, and the output register takes the shift/offset/saturate result.
// Stalls: each stage holds while the stage after it is full and stalled;
// in_ready drops only when all stages are full and out_ready is low.
// Reset: arst_n clears the pipeline valids and norm_enable; the parameter
// RAM is not cleared and must be loaded before its channels are sampled.
module batch_norm_scale_shift_saturate
	import bnss_pkg::*;
#(
	parameter int MAX_CHANNELS = BNSS_MAX_CHANNELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [7:0]        channel,
	input  logic signed [7:0] sample,
	input  logic signed [7:0] scale_in,
	input  logic signed [7:0] offset_in,
	input  logic [3:0]        shift_code_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] result
);

	localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CMP_W = $clog2(MAX_CHANNELS + 1) + 9;

	logic      norm_enable_q;
	logic      v_s1_q;
	logic      v_s2_q;
	logic      out_valid_q;

	logic      adv_s1;
	logic      adv_s2;
	logic      accept;
	logic      smp_acc;
	logic      ld_acc;
	logic      in_range;
	logic [AW-1:0] addr;
	param_t    wdata;
	param_t    rd;
	pipe_ctl_t ctl;

	assign adv_s2   = !out_valid_q || out_ready;
	assign adv_s1   = !v_s2_q || adv_s2;
	assign in_ready = !v_s1_q || adv_s1;

	assign accept   = in_valid && in_ready;
	assign in_range = CMP_W'(channel) < CMP_W'(MAX_CHANNELS);
	assign smp_acc  = accept && (req_type == REQ_SAMPLE);
	assign ld_acc   = accept && (req_type == REQ_LOAD) && in_range;
	assign addr     = AW'(channel);

	assign wdata.scale      = scale_in;
	assign wdata.offset     = offset_in;
	assign wdata.shift_code = shift_code_in;

	assign ctl.ld_s1  = smp_acc;
	assign ctl.ld_s2  = v_s1_q && adv_s1;
	assign ctl.ld_out = v_s2_q && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_enable_q <= 1'b0;
		end else if (cfg_we) begin
			norm_enable_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1_q <= smp_acc;
			end
			if (adv_s1) begin
				v_s2_q <= v_s1_q;
			end
			if (adv_s2) begin
				out_valid_q <= v_s2_q;
			end
		end
	end

	// at most one beat per cycle: a load and a read never share an edge
	bnss_param_mem #(
		.DEPTH (MAX_CHANNELS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (ld_acc),
		.waddr (addr),
		.wdata (wdata),
		.re    (smp_acc),
		.raddr (addr),
		.rdata (rd)
	);

	bnss_datapath u_dp (
		.clk      (clk),
		.ctl      (ctl),
		.sample   (sample),
		.en       (norm_enable_q),
		.in_range (in_range),
		.rd       (rd),
		.result   (result)
	);

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/bnss_checker.sv =====
module bnss_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              req_type,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [7:0] result
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result))
		else $error("result changed while stalled");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("out_valid high in reset");

	// input backs up only when the output is full and the sink stalls
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low with room in pipeline");

	// a result rising into an empty output follows its sample beat through stage 1, stage 2 and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && req_type, 3))
		else $error("result without matching sample beat");

endmodule

bind batch_norm_scale_shift_saturate bnss_checker u_bnss_checker (.*);
